// File: design/hse_pkg.sv
package hse_pkg;

    localparam int FifoDepth = 4;

    localparam logic [2:0] RegMode = 3'd0;
    localparam logic [2:0] RegKey0 = 3'd1;
    localparam logic [2:0] RegKey3 = 3'd4;

    typedef struct packed {
        logic [63:0] msg_bytes;
        logic [3:0]  byte_count;
        logic        last_chunk;
        logic        start;
        logic        hmac;
    } chunk_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_IN,
        ST_DATA,
        ST_PAD80,
        ST_PADZ,
        ST_LEN,
        ST_OKEY,
        ST_ODIG,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } state_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction

endpackage

// File: design/hse_front.sv
module hse_front
    import hse_pkg::*;
#(
    parameter int DEPTH = FifoDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] msg_bytes,
    input  logic [3:0]  byte_count,
    input  logic        last_chunk,
    input  logic        hmac_mode,
    output logic        q_valid,
    output chunk_t      q_data,
    input  logic        q_take
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    chunk_t          fifo_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     count_reg;
    logic            open_reg;
    chunk_t          item;
    logic            do_push, do_pop;

    assign full = (count_reg == (AW+1)'(DEPTH));
    assign do_push = push && !full;
    assign do_pop = q_take && q_valid;
    assign q_valid = (count_reg != '0);
    assign q_data = fifo_reg[rd_ptr_reg];

    // Classify: clamp the count and mark the chunk that opens a message.
    always_comb
    begin
        item.msg_bytes = msg_bytes;
        item.byte_count = (byte_count > 4'd8) ? 4'd8 : byte_count;
        item.last_chunk = last_chunk;
        item.start = !open_reg;
        item.hmac = hmac_mode;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
            open_reg <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
                open_reg <= !last_chunk;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end
endmodule

// File: design/hse_back.sv
module hse_back
    import hse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  chunk_t      q_data,
    output logic        q_take,
    input  logic [255:0] key,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);
    state_t        state_reg, state_next, ret_reg, ret_next;
    logic [31:0]   chain_reg [8];
    logic [31:0]   inner_reg [8];
    logic [31:0]   blk_reg [16];
    logic [31:0]   var_reg [8];
    logic [5:0]    fill_reg, fill_next;
    logic [63:0]   bits_reg, bits_next;
    logic          phase_hmac_reg, phase_hmac_next;
    logic          outer_reg, outer_next;
    chunk_t        cur_reg;
    logic [5:0]    cnt_reg, cnt_next;
    logic [5:0]    rnd_reg, rnd_next;
    logic [1:0]    widx_reg, widx_next;

    logic          byte_en, count_bits, load_cur, start_hash, comp_init, comp_step, fold;
    logic          save_inner;
    logic [7:0]    byte_val;

    logic [31:0]   w15, w2, g0, g1, wi, s1, ch, t1, s0, mj;

    assign w15 = blk_reg[1];
    assign w2 = blk_reg[14];
    assign g0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
    assign g1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
    // The block buffer doubles as the schedule window: it shifts one word per round.
    assign wi = (rnd_reg < 6'd16) ? blk_reg[0] : blk_reg[0] + g0 + blk_reg[9] + g1;
    assign s1 = {var_reg[4][5:0], var_reg[4][31:6]} ^ {var_reg[4][10:0], var_reg[4][31:11]}
              ^ {var_reg[4][24:0], var_reg[4][31:25]};
    assign ch = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
    assign t1 = var_reg[7] + s1 + ch + round_k(rnd_reg) + wi;
    assign s0 = {var_reg[0][1:0], var_reg[0][31:2]} ^ {var_reg[0][12:0], var_reg[0][31:13]}
              ^ {var_reg[0][21:0], var_reg[0][31:22]};
    assign mj = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
              ^ (var_reg[1] & var_reg[2]);

    assign empty = (state_reg != ST_OUT);
    assign digest_word = {chain_reg[{widx_reg, 1'b0}], chain_reg[{widx_reg, 1'b1}]};
    assign word_index = widx_reg;
    assign last_word = (widx_reg == 2'd3);

    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        fill_next = fill_reg;
        bits_next = bits_reg;
        phase_hmac_next = phase_hmac_reg;
        outer_next = outer_reg;
        cnt_next = cnt_reg;
        rnd_next = rnd_reg;
        widx_next = widx_reg;
        q_take = 1'b0;
        byte_en = 1'b0;
        count_bits = 1'b0;
        load_cur = 1'b0;
        start_hash = 1'b0;
        comp_init = 1'b0;
        comp_step = 1'b0;
        fold = 1'b0;
        save_inner = 1'b0;
        byte_val = 8'h00;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_take = 1'b1;
                    load_cur = 1'b1;
                    cnt_next = '0;
                    if (q_data.start)
                    begin
                        start_hash = 1'b1;
                        fill_next = '0;
                        bits_next = '0;
                        outer_next = 1'b0;
                        phase_hmac_next = q_data.hmac;
                        state_next = q_data.hmac ? ST_KEY_IN : ST_DATA;
                    end
                    else
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_KEY_IN, ST_OKEY, ST_DATA, ST_ODIG, ST_PAD80, ST_PADZ, ST_LEN:
            begin
                case (state_reg)
                    ST_KEY_IN, ST_OKEY:
                    begin
                        byte_val = (cnt_reg[5] ? 8'h00 : key[8'd255 - {cnt_reg[4:0], 3'b000} -: 8])
                                 ^ ((state_reg == ST_KEY_IN) ? 8'h36 : 8'h5c);
                        byte_en = 1'b1;
                        count_bits = 1'b1;
                    end
                    ST_ODIG:
                    begin
                        byte_val = inner_reg[cnt_reg[4:2]][8'd31 - {cnt_reg[1:0], 3'b000} -: 8];
                        byte_en = 1'b1;
                        count_bits = 1'b1;
                    end
                    ST_DATA:
                    begin
                        byte_val = cur_reg.msg_bytes[8'd63 - {cnt_reg[2:0], 3'b000} -: 8];
                        byte_en = (cnt_reg < 6'(cur_reg.byte_count));
                        count_bits = byte_en;
                    end
                    ST_PAD80:
                    begin
                        byte_val = 8'h80;
                        byte_en = 1'b1;
                    end
                    ST_PADZ:
                    begin
                        byte_val = 8'h00;
                        byte_en = (fill_reg != 6'd56);
                    end
                    default:
                    begin
                        byte_val = bits_reg[8'd63 - {cnt_reg[2:0], 3'b000} -: 8];
                        byte_en = 1'b1;
                    end
                endcase
                if (count_bits)
                begin
                    bits_next = bits_reg + 64'd8;
                end
                if (byte_en)
                begin
                    fill_next = fill_reg + 6'd1;
                    cnt_next = cnt_reg + 6'd1;
                end
                // Decide where this byte stream continues.
                case (state_reg)
                    ST_KEY_IN, ST_OKEY: ret_next = (cnt_reg == 6'd63) ? (state_reg == ST_KEY_IN ?
                        ST_DATA : ST_ODIG) : state_reg;
                    ST_ODIG:  ret_next = (cnt_reg == 6'd31) ? ST_PAD80 : ST_ODIG;
                    ST_PAD80: ret_next = ST_PADZ;
                    ST_PADZ:  ret_next = ST_PADZ;
                    ST_LEN:   ret_next = (cnt_reg == 6'd7) ? ST_FOLD : ST_LEN;
                    default:  ret_next = ST_DATA;
                endcase
                if (state_reg == ST_DATA && !byte_en)
                begin
                    cnt_next = '0;
                    state_next = cur_reg.last_chunk ? ST_PAD80 : ST_IDLE;
                end
                else if (state_reg == ST_PADZ && !byte_en)
                begin
                    cnt_next = '0;
                    state_next = ST_LEN;
                end
                else if (byte_en && fill_reg == 6'd63)
                begin
                    comp_init = 1'b1;
                    rnd_next = '0;
                    state_next = ST_COMP;
                    if (ret_next != state_reg)
                    begin
                        cnt_next = '0;
                    end
                end
                else if (ret_next != state_reg)
                begin
                    cnt_next = '0;
                    state_next = ret_next;
                end
            end
            ST_COMP:
            begin
                // The byte position in cnt_reg is kept so a chunk resumes where it stopped.
                comp_step = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    fold = 1'b1;
                    state_next = ret_reg;
                end
            end
            ST_FOLD:
            begin
                // Length block is done: the digest is in the chain.
                cnt_next = '0;
                if (phase_hmac_reg && !outer_reg)
                begin
                    save_inner = 1'b1;
                    start_hash = 1'b1;
                    fill_next = '0;
                    bits_next = '0;
                    outer_next = 1'b1;
                    state_next = ST_OKEY;
                end
                else
                begin
                    widx_next = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (pop)
                begin
                    widx_next = widx_reg + 2'd1;
                    if (widx_reg == 2'd3)
                    begin
                        start_hash = 1'b1;
                        fill_next = '0;
                        bits_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg <= ST_IDLE;
            fill_reg <= '0;
            bits_reg <= '0;
            phase_hmac_reg <= 1'b0;
            outer_reg <= 1'b0;
            cnt_reg <= '0;
            rnd_reg <= '0;
            widx_reg <= '0;
            chain_reg <= INIT_HASH;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            fill_reg <= fill_next;
            bits_reg <= bits_next;
            phase_hmac_reg <= phase_hmac_next;
            outer_reg <= outer_next;
            cnt_reg <= cnt_next;
            rnd_reg <= rnd_next;
            widx_reg <= widx_next;
            if (start_hash)
            begin
                chain_reg <= INIT_HASH;
            end
            else if (fold)
            begin
                chain_reg[0] <= chain_reg[0] + t1 + s0 + mj;
                chain_reg[1] <= chain_reg[1] + var_reg[0];
                chain_reg[2] <= chain_reg[2] + var_reg[1];
                chain_reg[3] <= chain_reg[3] + var_reg[2];
                chain_reg[4] <= chain_reg[4] + var_reg[3] + t1;
                chain_reg[5] <= chain_reg[5] + var_reg[4];
                chain_reg[6] <= chain_reg[6] + var_reg[5];
                chain_reg[7] <= chain_reg[7] + var_reg[6];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_cur)
        begin
            cur_reg <= q_data;
        end
        if (save_inner)
        begin
            inner_reg <= chain_reg;
        end
        if (byte_en)
        begin
            blk_reg[fill_reg[5:2]][8'd31 - {fill_reg[1:0], 3'b000} -: 8] <= byte_val;
        end
        if (comp_init)
        begin
            var_reg <= chain_reg;
        end
        else if (comp_step)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + s0 + mj;
        end
        if (comp_step)
        begin
            for (int j = 0; j < 15; j++)
            begin
                blk_reg[j] <= blk_reg[j+1];
            end
            blk_reg[15] <= wi;
        end
    end
endmodule

// File: design/hmac_sha256_engine_unit.sv
// Streaming SHA-256 / HMAC-SHA256 engine.
// Input: message chunks of up to eight bytes (first byte in bits 63:56) are
// pushed while full is low; last_chunk closes the message.
// Output: four 64-bit digest words, word_index 0 to 3, leave through a
// queue-like port: a word waits while empty is low and moves on each pop.
// Configuration: index 0 selects HMAC, indexes 1 to 4 hold the 32-byte key.
// Write it only while idle; the mode is taken when a message opens.
// A front queue of four chunks absorbs input while the back end works.
// The back end takes a chunk, writes its bytes into the block one by one, closes the
// chunk, and runs the rounds of each 64-byte block. Padding after the last chunk adds
// one or two blocks, and HMAC adds an inner key block plus a full outer hash.
// Reset empties the queue, closes any open message and loads the initial
// hash values. A stalled result side holds the digest and stops the back end;
// the front queue keeps accepting until it fills.
module hmac_sha256_engine_unit
    import hse_pkg::*;
#(
    parameter int FIFO_DEPTH = FifoDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] msg_bytes,
    input  logic [3:0]  byte_count,
    input  logic        last_chunk,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    logic        hmac_mode_reg;
    logic [63:0] key_reg [4];
    logic [255:0] key;
    logic        q_valid, q_take;
    chunk_t      q_data;

    assign cfg_ready = 1'b1;
    assign key = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hmac_mode_reg <= 1'b0;
            key_reg <= '{default: '0};
        end
        else if (cfg_valid)
        begin
            if (cfg_index == RegMode)
            begin
                hmac_mode_reg <= cfg_data[0];
            end
            else if (cfg_index >= RegKey0 && cfg_index <= RegKey3)
            begin
                key_reg[2'(cfg_index - RegKey0)] <= cfg_data;
            end
        end
    end

    hse_front #(.DEPTH(FIFO_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .msg_bytes(msg_bytes), .byte_count(byte_count), .last_chunk(last_chunk),
        .hmac_mode(hmac_mode_reg), .q_valid(q_valid), .q_data(q_data), .q_take(q_take)
    );

    hse_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .q_take(q_take),
        .key(key), .empty(empty), .pop(pop), .digest_word(digest_word),
        .word_index(word_index), .last_word(last_word)
    );

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_word) |=> (word_index == $past(word_index) + 2'd1))
        else $error("digest word index did not advance");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(digest_word) && $stable(word_index)))
        else $error("stalled digest word changed");
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> (word_index == 2'd0))
        else $error("digest did not start at word zero");
endmodule

// File: tb/hmac_sha256_engine_unit_tb.sv
module hmac_sha256_engine_unit_tb
    import hse_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 8000;
    localparam int SettleCycles = 600;
    localparam int RandomChunks = 360;

    localparam logic [7:0] InnerPad = 8'h36;
    localparam logic [7:0] OuterPad = 8'h5c;
    localparam logic [7:0] PadMarker = 8'h80;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [31:0] SHA_H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    typedef enum int {
        MSG_IDLE,
        MSG_PLAIN,
        MSG_HMAC
    } msg_state_t;

    typedef struct {
        logic [63:0] digest;
        logic [1:0]  index;
        logic        last;
    } digest_word_t;

    class digest_board;
        logic [31:0]    chain [8];
        logic [31:0]    blk [16];
        int unsigned    fill;
        logic [63:0]    nbits;
        msg_state_t     state;
        logic           mode;
        logic [63:0]    key [4];
        digest_word_t   pending [$];
        int             errors;

        function new();
            mode = 1'b0;
            foreach (key[i]) key[i] = '0;
            foreach (blk[i]) blk[i] = '0;
            state = MSG_IDLE;
            errors = 0;
            restart();
        endfunction

        function void write_reg(logic [2:0] index, logic [63:0] data);
            if (index == RegMode)
                mode = data[0];
            else if (index <= RegKey3)
                key[index - RegKey0] = data;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [16];
            logic [31:0] v [8];
            logic [31:0] wi, s0, s1, ch, mj, t1, w15, w2;
            for (int i = 0; i < 16; i++) w[i] = blk[i];
            for (int i = 0; i < 8; i++) v[i] = chain[i];
            for (int i = 0; i < 64; i++)
            begin
                if (i < 16)
                    wi = w[i];
                else
                begin
                    w15 = w[(i - 15) & 15];
                    w2 = w[(i - 2) & 15];
                    wi = w[i & 15] + (ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3))
                        + w[(i - 7) & 15] + (ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10));
                    w[i & 15] = wi;
                end
                s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
                ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
                t1 = v[7] + s1 + ch + SHA_K[i] + wi;
                s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
                mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + s0 + mj;
            end
            for (int i = 0; i < 8; i++) chain[i] += v[i];
        endfunction

        function void put_byte(logic [7:0] b);
            int unsigned pos;
            pos = fill & 63;
            blk[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = b;
            fill = pos + 1;
            if (fill == 64)
            begin
                compress();
                fill = 0;
            end
        endfunction

        function void absorb(logic [7:0] b);
            put_byte(b);
            nbits += 64'd8;
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = SHA_H0[i];
            fill = 0;
            nbits = '0;
        endfunction

        function void absorb_key(logic [7:0] pad);
            logic [7:0] kb;
            for (int i = 0; i < 64; i++)
            begin
                kb = (i < 32) ? key[i >> 3][(7 - (i & 7)) * 8 +: 8] : 8'h00;
                absorb(kb ^ pad);
            end
        endfunction

        function void close_message();
            logic [63:0] len;
            len = nbits;
            put_byte(PadMarker);
            while (fill != 56) put_byte(8'h00);
            for (int i = 7; i >= 0; i--) put_byte(len[i * 8 +: 8]);
        endfunction

        function void note_chunk(logic [63:0] data, logic [3:0] count, logic last);
            int unsigned n;
            logic [31:0] inner [8];
            digest_word_t dw;
            n = (count > 8) ? 8 : count;
            if (state == MSG_IDLE)
            begin
                restart();
                if (mode)
                begin
                    state = MSG_HMAC;
                    absorb_key(InnerPad);
                end
                else
                    state = MSG_PLAIN;
            end
            for (int i = 0; i < n; i++) absorb(data[(7 - i) * 8 +: 8]);
            if (!last)
                return;
            close_message();
            if (state == MSG_HMAC)
            begin
                for (int i = 0; i < 8; i++) inner[i] = chain[i];
                restart();
                absorb_key(OuterPad);
                for (int i = 0; i < 32; i++) absorb(inner[i >> 2][(3 - (i & 3)) * 8 +: 8]);
                close_message();
            end
            for (int i = 0; i < 4; i++)
            begin
                dw.digest = {chain[2 * i], chain[2 * i + 1]};
                dw.index = i[1:0];
                dw.last = (i == 3);
                pending.insert(pending.size(), dw);
            end
            restart();
            state = MSG_IDLE;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_word(logic [63:0] digest, logic [1:0] index, logic last);
            digest_word_t exp_word;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected digest word %h", digest));
                return;
            end
            exp_word = pending.pop_front();
            if (digest !== exp_word.digest)
                report($sformatf("digest_word %h, want %h", digest, exp_word.digest));
            if (index !== exp_word.index)
                report($sformatf("word_index %0d, want %0d", index, exp_word.index));
            if (last !== exp_word.last)
                report($sformatf("last_word %b, want %b", last, exp_word.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [63:0] msg_bytes;
    logic [3:0]  byte_count;
    logic        last_chunk;
    logic        empty;
    logic        pop;
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    digest_board board;
    int          burst_left;
    int          idle_cycles;
    int          pop_tick;
    int          stall_left;
    int          chunks_sent;

    hmac_sha256_engine_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .msg_bytes  (msg_bytes),
        .byte_count (byte_count),
        .last_chunk (last_chunk),
        .empty      (empty),
        .pop        (pop),
        .digest_word(digest_word),
        .word_index (word_index),
        .last_word  (last_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Every transfer is observed here, before the block's own updates land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (push && !full)
            begin
                board.note_chunk(msg_bytes, byte_count, last_chunk);
                idle_cycles = 0;
            end
            if (pop && !empty)
            begin
                board.check_word(digest_word, word_index, last_word);
                idle_cycles = 0;
            end
            if (cfg_valid && cfg_ready)
            begin
                board.write_reg(cfg_index, cfg_data);
                idle_cycles = 0;
            end
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // The result side cycles through free running, coin flips and long stalls.
    always @(negedge clk)
    begin
        pop_tick++;
        case ((pop_tick / 300) % 3)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    pop <= 1'b0;
                end
                else
                begin
                    pop <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        stall_left = $urandom_range(1, 40);
                end
            end
        endcase
    end

    task send_chunk(logic [63:0] data, logic [3:0] count, logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        msg_bytes <= data;
        byte_count <= count;
        last_chunk <= last;
        do @(posedge clk); while (full);
        @(negedge clk);
        chunks_sent++;
    endtask

    // Holds off the sender until every digest word has arrived and the block settles.
    task drain();
        push <= 1'b0;
        burst_left = 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task write_reg(logic [2:0] index, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task send_message(int chunks, logic [63:0] fill_value, logic [3:0] count);
        for (int i = 0; i < chunks; i++)
            send_chunk(fill_value, count, i == chunks - 1);
    endtask

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return {$urandom, 32'h0};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task random_message();
        int          chunks;
        logic [3:0]  count;
        logic [63:0] data;
        chunks = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
        for (int i = 0; i < chunks; i++)
        begin
            case ($urandom_range(0, 9))
                0: count = 4'($urandom_range(0, 15));
                1, 2: count = 4'($urandom_range(1, 7));
                default: count = 4'd8;
            endcase
            data = {$urandom, $urandom};
            send_chunk(data, count, i == chunks - 1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        msg_bytes = '0;
        byte_count = '0;
        last_chunk = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 0;
        idle_cycles = 0;
        pop_tick = 0;
        stall_left = 0;
        chunks_sent = 0;
        board = new();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Plain hashing: empty message, short text, oversized count, an empty
        // chunk that opens a message, and lengths around the padding boundary.
        send_chunk('0, 4'd0, 1'b1);
        send_chunk(64'h6162630000000000, 4'd3, 1'b1);
        send_chunk('1, 4'd0, 1'b0);
        send_chunk(64'h6162630000000000, 4'd3, 1'b1);
        send_chunk('1, 4'd15, 1'b1);
        send_message(7, '0, 4'd8);
        send_message(8, '1, 4'd8);
        drain();

        // Out-of-range indexes must leave the registers alone.
        for (int i = RegKey3 + 1; i < 8; i++) write_reg(3'(i), '1);
        write_reg(RegMode, '1);
        for (int i = RegKey0; i <= RegKey3; i++) write_reg(3'(i), '1);
        send_chunk(64'h6162630000000000, 4'd3, 1'b1);
        send_chunk('0, 4'd0, 1'b1);
        send_message(2, '1, 4'd8);
        drain();

        while (chunks_sent < RandomChunks)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                drain();
                write_reg(RegMode, {$urandom, $urandom});
                for (int i = RegKey0; i <= RegKey3; i++)
                    if ($urandom_range(0, 1) == 0) write_reg(3'(i), pick_key());
                if ($urandom_range(0, 4) == 0)
                    write_reg(3'($urandom_range(RegKey3 + 1, 7)), {$urandom, $urandom});
            end
            random_message();
        end
        drain();

        while (board.pending.size() != 0)
        begin
            board.report("digest word never arrived");
            void'(board.pending.pop_front());
        end
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
